// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/nsr_pkg.sv =====
// Package: widths, codes and constants of the Newton square-root unit.
package nsr_pkg;

  localparam int DATA_W   = 32;             // operand width, signed
  localparam int FRAC_W   = 16;             // fraction bits
  localparam int Y_W      = DATA_W - 1;     // estimate width, unsigned
  localparam int MAG_W    = 2 * Y_W;        // |y*y - t<<FRAC_W|, quotient width
  localparam int D_W      = Y_W + 1;        // divisor 2*y
  localparam int TOL_W    = 16;
  localparam int ITER_W   = 10;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = ((Y_W + ITER_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STAT_W + 1;

  localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_W;
  localparam logic [Y_W-1:0]    MAX_POS = {Y_W{1'b1}};

  localparam logic [TOL_W-1:0]  TOL_RESET   = TOL_W'(1);
  localparam logic [ITER_W-1:0] MAXIT_RESET = ITER_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAXIT = CFG_IDX_W'(1);

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NEG   = 2'd1;
  localparam status_t ST_NOBRK = 2'd2;

endpackage

// ===== design/nsr_mul.sv =====
// Bit-serial shift-add squarer: one multiplier bit per cycle.
module nsr_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsr_pkg::Y_W-1:0]    y,
  output logic                       busy,
  output logic                       done,
  output logic [nsr_pkg::MAG_W-1:0]  prod
);
  import nsr_pkg::*;

  localparam int CNT_W = $clog2(Y_W + 1);

  logic [2*Y_W:0]   acc_r, acc_nxt;
  logic [Y_W-1:0]   mcand_r, mcand_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [Y_W:0]     sum;

  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    sum = acc_r[2*Y_W:Y_W] + (acc_r[0] ? {1'b0, mcand_r} : '0);
    if (start) begin
      acc_nxt   = {{(Y_W+1){1'b0}}, y};
      mcand_nxt = y;
      cnt_nxt   = CNT_W'(Y_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {1'b0, sum, acc_r[Y_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r[MAG_W-1:0];

endmodule

// ===== design/nsr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module nsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsr_pkg::MAG_W-1:0]  dividend,
  input  logic [nsr_pkg::D_W-1:0]    divisor,
  output logic                       busy,
  output logic                       done,
  output logic [nsr_pkg::MAG_W-1:0]  quotient
);
  import nsr_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [D_W:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0] quo_r, quo_nxt;
  logic [D_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [D_W:0]     r_sh, diff;
  logic             ge;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    r_sh = {rem_r[D_W-1:0], quo_r[MAG_W-1]};
    diff = r_sh - {1'b0, dvs_r};
    ge   = (r_sh >= {1'b0, dvs_r});
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : r_sh;
      quo_nxt = {quo_r[MAG_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/newton_square_root_unit.sv =====
// Top level: Newton square-root unit with stream ports and a register write port.
// One operand at a time. Negative operands and operands above zero up to 1.0 are
// rejected and zero returns a converged zero root, all without iterating. Otherwise
// each Newton iteration issues the bit-serial squarer, then runs the bit-serial
// divider, then updates the estimate and checks it, for up to the iteration cap.
// The serial divider dominates. A finished result sits in the output register
// while the next operand is accepted.
module newton_square_root_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [nsr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // operand stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nsr_pkg::DATA_W-1:0]      in_tdata,   // operand
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nsr_pkg::OUT_DATA_W-1:0]  out_tdata,  // root, iterations_used, zero pad
  output logic [nsr_pkg::OUT_USER_W-1:0]  out_tuser   // status, converged
);
  import nsr_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ITER = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [TOL_W-1:0] tol_r;
  logic [ITER_W-1:0] maxit_r;

  logic [Y_W-1:0]    t_r, t_nxt;
  logic [Y_W-1:0]    y_r, y_nxt;
  logic [Y_W-1:0]    ynew_r, ynew_nxt;
  logic [ITER_W-1:0] it_r, it_nxt;
  logic              neg_r, neg_nxt;     // sign of y*y - (t << FRAC_W)
  logic [Y_W-1:0]    res_root_r, res_root_nxt;
  status_t           res_stat_r, res_stat_nxt;
  logic              res_conv_r, res_conv_nxt;
  logic [ITER_W-1:0] res_it_r, res_it_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [Y_W-1:0]    out_root_r, out_root_nxt;
  status_t           out_stat_r, out_stat_nxt;
  logic              out_conv_r, out_conv_nxt;
  logic [ITER_W-1:0] out_it_r, out_it_nxt;

  logic              mul_start, mul_busy, mul_done;
  logic [MAG_W-1:0]  prod;
  logic              div_start, div_busy, div_done;
  logic [MAG_W-1:0]  div_mag, quot;

  logic              in_fire;
  logic [MAG_W-1:0]  t_sh;
  logic              prod_lt;
  logic [MAG_W:0]    upd_sum;
  logic [Y_W:0]      dlt;
  logic [Y_W-1:0]    dlt_abs;

  nsr_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .y(y_r),
    .busy(mul_busy), .done(mul_done), .prod(prod)
  );

  nsr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_mag),
    .divisor({y_r, 1'b0}), .busy(div_busy), .done(div_done), .quotient(quot)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // y*y - (t << FRAC_W): sign and magnitude for the divider
  assign t_sh      = MAG_W'(t_r) << FRAC_W;
  assign prod_lt   = (prod < t_sh);
  assign div_mag   = prod_lt ? (t_sh - prod) : (prod - t_sh);
  assign mul_start = (state_r == S_ITER) && (it_r != maxit_r) && (y_r != '0);
  assign div_start = (state_r == S_MUL) && mul_done;

  // update: y - corr, saturated to [0, MAX_POS]
  assign upd_sum = neg_r ? ({1'b0, MAG_W'(y_r)} + {1'b0, quot})
                         : ({1'b0, MAG_W'(y_r)} - {1'b0, quot});

  // |ynew - y|
  assign dlt     = {1'b0, ynew_r} - {1'b0, y_r};
  assign dlt_abs = dlt[Y_W] ? Y_W'(-dlt) : dlt[Y_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    t_nxt        = t_r;
    y_nxt        = y_r;
    ynew_nxt     = ynew_r;
    it_nxt       = it_r;
    neg_nxt      = neg_r;
    res_root_nxt = res_root_r;
    res_stat_nxt = res_stat_r;
    res_conv_nxt = res_conv_r;
    res_it_nxt   = res_it_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_root_nxt = out_root_r;
    out_stat_nxt = out_stat_r;
    out_conv_nxt = out_conv_r;
    out_it_nxt   = out_it_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_root_nxt = '0;
          res_conv_nxt = 1'b0;
          res_it_nxt   = '0;
          res_stat_nxt = ST_OK;
          if (in_tdata[DATA_W-1]) begin
            res_stat_nxt = ST_NEG;
            state_nxt    = S_FIN;
          end else if (in_tdata == '0) begin
            res_conv_nxt = 1'b1;
            state_nxt    = S_FIN;
          end else if (in_tdata <= ONE_FIX) begin
            res_stat_nxt = ST_NOBRK;
            state_nxt    = S_FIN;
          end else begin
            t_nxt     = in_tdata[Y_W-1:0];
            y_nxt     = in_tdata[Y_W-1:0];
            it_nxt    = '0;
            state_nxt = S_ITER;
          end
        end
      end
      S_ITER: begin
        if (!mul_start) begin
          // cap reached or estimate at zero
          res_root_nxt = y_r;
          res_conv_nxt = 1'b0;
          res_it_nxt   = it_r;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          neg_nxt   = prod_lt;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_sum[MAG_W]) ynew_nxt = '0;
        else if (upd_sum[MAG_W-1:0] > MAG_W'(MAX_POS)) ynew_nxt = MAX_POS;
        else ynew_nxt = upd_sum[Y_W-1:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        it_nxt = it_r + 1'b1;
        y_nxt  = ynew_r;
        if (dlt_abs < Y_W'(tol_r)) begin
          res_root_nxt = ynew_r;
          res_conv_nxt = 1'b1;
          res_it_nxt   = it_r + 1'b1;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_ITER;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = res_root_r;
          out_stat_nxt  = res_stat_r;
          out_conv_nxt  = res_conv_r;
          out_it_nxt    = res_it_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    y_r        <= y_nxt;
    ynew_r     <= ynew_nxt;
    it_r       <= it_nxt;
    neg_r      <= neg_nxt;
    res_root_r <= res_root_nxt;
    res_stat_r <= res_stat_nxt;
    res_conv_r <= res_conv_nxt;
    res_it_r   <= res_it_nxt;
    out_root_r <= out_root_nxt;
    out_stat_r <= out_stat_nxt;
    out_conv_r <= out_conv_nxt;
    out_it_r   <= out_it_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_RESET;
      maxit_r     <= MAXIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_TOL:   tol_r   <= cfg_wdata[TOL_W-1:0];
          CFG_MAXIT: maxit_r <= cfg_wdata[ITER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_it_r, out_root_r});
  assign out_tuser  = {out_conv_r, out_stat_r};

  // squarer and divider never run together
  `ASSERT_CLK(a_units_exclusive, !(mul_busy && div_busy), "squarer and divider both busy")
  // a rejected operand carries no root and no iterations
  `ASSERT_CLK(a_reject_zero,
    !(out_valid_r && (out_stat_r == ST_NEG || out_stat_r == ST_NOBRK)) ||
    (out_root_r == '0 && out_it_r == '0 && !out_conv_r), "rejected operand with data")
  // the divider starts only on the squarer finishing
  `ASSERT_NEXT(a_div_follows_mul, mul_done && state_r == S_MUL, div_busy,
    "divider did not start after squarer")
  // iteration count never passes the cap
  `ASSERT_CLK(a_iter_cap, !(state_r == S_CHK) || (it_r < maxit_r), "iteration past cap")

endmodule

// ===== sim/newton_square_root_unit_test.sv =====
// Testbench for the Newton square-root unit: directed and random operands, checked per result.
module newton_square_root_unit_test;
  import nsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;  // idle cycles, enough for one operand at the largest cap

  // Expected content of one result transaction.
  typedef struct {
    logic [Y_W-1:0]    root;
    status_t           status;
    logic              converged;
    logic [ITER_W-1:0] iters;
  } root_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // Local copy of the two registers.
  logic [TOL_W-1:0]  tol_q;
  logic [ITER_W-1:0] maxit_q;

  root_result_t expected_roots[$];
  int fail_count;
  int idle_cycles;

  // Sender burst shaping.
  int burst_left;
  int gap_max;
  // Receiver stall shaping: percent of cycles ready, changed per phase.
  int ready_pct;

  newton_square_root_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Newton iteration in 64-bit signed arithmetic; division truncates toward zero.
  function automatic root_result_t predict_root(logic [DATA_W-1:0] raw);
    root_result_t r;
    longint t;
    longint y_old;
    longint y_new;
    longint num;
    longint corr;
    longint delta;
    int it;
    t = longint'($signed(raw));
    r.root = '0;
    r.status = ST_OK;
    r.converged = 1'b0;
    r.iters = '0;
    if (t < 0) begin
      r.status = ST_NEG;
      return r;
    end
    if (t == 0) begin
      r.converged = 1'b1;
      return r;
    end
    // bracket test only passes above 1.0
    if (t <= longint'(ONE_FIX)) begin
      r.status = ST_NOBRK;
      return r;
    end
    y_old = t;
    y_new = t;
    for (it = 0; it < int'(maxit_q); it++) begin
      if (y_old == 0) break;
      num = y_old * y_old - (t <<< FRAC_W);
      corr = num / (2 * y_old);
      y_new = y_old - corr;
      if (y_new < 0) y_new = 0;
      if (y_new > longint'(MAX_POS)) y_new = longint'(MAX_POS);
      delta = y_new - y_old;
      if (delta < 0) delta = -delta;
      if (delta < longint'(tol_q)) begin
        r.root = y_new[Y_W-1:0];
        r.converged = 1'b1;
        r.iters = ITER_W'(it + 1);
        return r;
      end
      y_old = y_new;
    end
    r.root = y_new[Y_W-1:0];
    r.iters = ITER_W'(it);
    return r;
  endfunction

  // Register write; block must be idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOL) tol_q = val[TOL_W-1:0];
    else if (idx == CFG_MAXIT) maxit_q = val[ITER_W-1:0];
  endtask

  // Send one operand transaction, with random gaps between bursts.
  task automatic send_operand(logic [DATA_W-1:0] operand);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= operand;
    do @(posedge clk); while (!in_tready);
    expected_roots.push_back(predict_root(operand));
  endtask

  // Drop valid, drain all expected results, then allow for trailing work.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (expected_roots.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Operand mix: rejects, near-one values, small roots and full-range values.
  function automatic logic [DATA_W-1:0] random_operand();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return DATA_W'(32'h8000_0000 | $urandom());
    if (sel < 18) return DATA_W'($urandom_range(0, 32'h0001_0002));
    if (sel < 45) return DATA_W'($urandom_range(32'h0001_0001, 32'h0100_0000));
    return DATA_W'($urandom() & 32'h7FFF_FFFF);
  endfunction

  task automatic test_directed_at_reset();
    gap_max = 0;
    ready_pct = 100;
    send_operand(32'h0000_0000);   // zero
    send_operand(32'h0000_0001);   // tiny, not bracketed
    send_operand(32'h0001_0000);   // exactly one
    send_operand(32'h0001_0001);   // just above one
    send_operand(32'h0002_0000);
    send_operand(32'h0004_0000);
    send_operand(32'h0010_0000);
    send_operand(32'h7FFF_FFFF);   // largest positive
    send_operand(32'h8000_0000);   // most negative
    send_operand(32'hFFFF_FFFF);   // minus one LSB
    send_operand(32'h5555_5555);
    send_operand(32'h2AAA_AAAA);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    // widest tolerance and single-update cap
    write_reg(CFG_TOL, 16'hFFFF);
    write_reg(CFG_MAXIT, 16'd1);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'h0009_0000);
    send_operand(32'h0001_8000);
    wait_idle();
    // indexes past the two registers change nothing
    write_reg(2'd2, 16'h0000);
    write_reg(2'd3, 16'h0000);
    send_operand(32'h0100_0000);
    wait_idle();
    // longest cap with tightest tolerance
    write_reg(CFG_TOL, 16'd1);
    write_reg(CFG_MAXIT, 16'd1023);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'h0003_0000);
    wait_idle();
    // cap short enough to stop before convergence
    write_reg(CFG_MAXIT, 16'd3);
    send_operand(32'h7FFF_FFFF);
    send_operand(32'h1234_5678);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          write_reg(CFG_TOL, CFG_DATA_W'($urandom_range(1, 16)));
          write_reg(CFG_MAXIT, CFG_DATA_W'($urandom_range(20, 1023)));
        end
        1: begin
          write_reg(CFG_TOL, CFG_DATA_W'($urandom_range(1, 65535)));
          write_reg(CFG_MAXIT, CFG_DATA_W'($urandom_range(1, 40)));
        end
        2: begin
          write_reg(CFG_TOL, CFG_DATA_W'($urandom_range(1, 4)));
          write_reg(CFG_MAXIT, CFG_DATA_W'($urandom_range(1, 8)));
        end
        default: begin
          write_reg(CFG_TOL, CFG_DATA_W'($urandom_range(1, 65535)));
          write_reg(CFG_MAXIT, CFG_DATA_W'($urandom_range(1, 1023)));
        end
      endcase
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 10);
      ready_pct = (phase % 3 == 1) ? 100 : $urandom_range(20, 90);
      for (n = 0; n < 102; n++) send_operand(random_operand());
      wait_idle();
    end
  endtask

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    root_result_t exp_r;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("newton_square_root_unit regression: fail");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (expected_roots.size() == 0) begin
          $error("unexpected result transaction, tdata %h tuser %h", out_tdata, out_tuser);
          fail_count++;
        end else begin
          exp_r = expected_roots.pop_front();
          if (out_tdata[Y_W-1:0] !== exp_r.root) begin
            $error("root: expected %h actual %h", exp_r.root, out_tdata[Y_W-1:0]);
            fail_count++;
          end
          if (out_tdata[Y_W+ITER_W-1:Y_W] !== exp_r.iters) begin
            $error("iterations_used: expected %0d actual %0d", exp_r.iters,
                   out_tdata[Y_W+ITER_W-1:Y_W]);
            fail_count++;
          end
          if (out_tuser[STAT_W-1:0] !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_tuser[STAT_W-1:0]);
            fail_count++;
          end
          if (out_tuser[STAT_W] !== exp_r.converged) begin
            $error("converged: expected %b actual %b", exp_r.converged, out_tuser[STAT_W]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    tol_q = TOL_RESET;
    maxit_q = MAXIT_RESET;
    fail_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_max = 0;
    ready_pct = 100;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_at_reset();
    test_config_extremes();
    test_random_phases();
    if (expected_roots.size() != 0) begin
      $error("%0d expected results never arrived", expected_roots.size());
      fail_count++;
    end
    if (fail_count == 0) $display("newton_square_root_unit regression: pass");
    else $display("newton_square_root_unit regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/nsr_pkg.sv
design/nsr_mul.sv
design/nsr_div.sv
design/newton_square_root_unit.sv
sim/newton_square_root_unit_test.sv
